// ===== src/kdpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_pkg
// Shared types and constants of the key debounce and press classifier.
// ----------------------------------------------------------------------------
package kdpc_pkg;

  localparam int unsigned TimeWidthDef = 32;
  localparam int unsigned CfgWidth     = 32;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [7:0]  DebounceLimitRst = 8'd5;
  localparam logic [31:0] LongTimeRst      = 32'd30000;
  localparam logic [31:0] LongLongTimeRst  = 32'd50000;
  localparam logic [7:0]  CountMax         = 8'hFF;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE_LIMIT = 2'd0,
    REG_LONG_TIME      = 2'd1,
    REG_LONG_LONG_TIME = 2'd2
  } kdpc_reg_e;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_SHORT     = 2'd1,
    EV_LONG      = 2'd2,
    EV_LONG_LONG = 2'd3
  } kdpc_event_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HELD   = 3'b010,
    PH_REPORT = 3'b100
  } kdpc_phase_e;

  typedef struct packed {
    logic [7:0]  debounce_limit;
    logic [31:0] long_time;
    logic [31:0] long_long_time;
  } kdpc_cfg_t;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_time;
    logic        inhibit;
  } kdpc_item_t;

  typedef struct packed {
    logic        debounced_level;
    kdpc_event_e press_event;
    logic        press_began;
    logic        long_reached;
    logic        long_long_reached;
  } kdpc_result_t;

endpackage
`default_nettype wire

// ===== src/kdpc_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_tracker
// Debounce state and press-phase machine; one tick is applied per enable.
// ----------------------------------------------------------------------------
module kdpc_tracker import kdpc_pkg::*; #(
  parameter int unsigned TimeWidth = TimeWidthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire kdpc_cfg_t    cfg_i,
  input  wire kdpc_item_t   item_i,
  output kdpc_result_t      res_o
);

  localparam int unsigned CmpWidth = (TimeWidth > 32) ? TimeWidth : 32;

  logic                 level_q, level_d;
  logic [7:0]           cnt_q, cnt_d;
  kdpc_phase_e          phase_q, phase_d;
  logic [TimeWidth-1:0] start_q, start_d;
  logic                 long_q, long_d;
  logic                 llong_q, llong_d;

  logic [7:0]           cnt_inc;
  logic [CmpWidth-1:0]  now_ext;
  logic [TimeWidth-1:0] now_t;
  logic [TimeWidth-1:0] elapsed;
  logic [CmpWidth-1:0]  elapsed_ext;
  kdpc_event_e          event_d;
  logic                 began_d;

  assign now_ext     = CmpWidth'(item_i.now_time);
  assign now_t       = now_ext[TimeWidth-1:0];
  assign elapsed     = now_t - start_q;
  assign elapsed_ext = CmpWidth'(elapsed);
  assign cnt_inc     = (cnt_q == CountMax) ? CountMax : cnt_q + 8'd1;

  always_comb begin
    level_d = level_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    start_d = start_q;
    long_d  = long_q;
    llong_d = llong_q;
    event_d = EV_NONE;
    began_d = 1'b0;
    if (!item_i.inhibit) begin
      if (item_i.pin_level == level_q) begin
        cnt_d = 8'd0;
      end else if (cnt_inc > cfg_i.debounce_limit) begin
        level_d = item_i.pin_level;
        cnt_d   = 8'd0;
      end else begin
        cnt_d = cnt_inc;
      end
      unique case (phase_q)
        PH_HELD: begin
          if (!level_d) begin
            if (elapsed_ext > CmpWidth'(cfg_i.long_time)) long_d = 1'b1;
            if (elapsed_ext > CmpWidth'(cfg_i.long_long_time)) llong_d = 1'b1;
          end else begin
            phase_d = PH_REPORT;
          end
        end
        PH_REPORT: begin
          if (llong_q) begin
            long_d  = 1'b0;
            event_d = EV_LONG_LONG;
          end else if (long_q) begin
            event_d = EV_LONG;
          end else begin
            event_d = EV_SHORT;
          end
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
          if (!level_d) begin
            start_d = now_t;
            phase_d = PH_HELD;
            long_d  = 1'b0;
            llong_d = 1'b0;
            began_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_o.debounced_level   = level_d;
    res_o.press_event       = event_d;
    res_o.press_began       = began_d;
    res_o.long_reached      = long_d;
    res_o.long_long_reached = llong_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b1;
      cnt_q   <= 8'd0;
      phase_q <= PH_IDLE;
      long_q  <= 1'b0;
      llong_q <= 1'b0;
    end else if (en_i) begin
      level_q <= level_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      long_q  <= long_d;
      llong_q <= llong_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      start_q <= start_d;
    end
  end

`ifndef SYNTH
  a_event_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.press_event != EV_NONE) |-> (phase_q == PH_REPORT && !item_i.inhibit))
    else $error("press event outside report phase");

  a_began_enters_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.press_began) |=> (phase_q == PH_HELD && !long_q && !llong_q))
    else $error("press start did not enter held phase");

  a_inhibit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && item_i.inhibit) |=> ($stable(level_q) && $stable(phase_q) &&
                                  $stable(cnt_q) && $stable(long_q)))
    else $error("inhibited tick changed state");

  a_long_long_clears_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.press_event == EV_LONG_LONG) |=> (!long_q && llong_q))
    else $error("long-long report left long flag set");
`endif

endmodule
`default_nettype wire

// ===== src/key_debounce_press_classifier_unit.sv =====
`default_nettype none
// An accepted tick is held in the input register, then its result in the result register.
// Throughput: one tick per cycle; the input register empties into the result
// register whenever that register is free or being taken.
// Reset: asynchronous, active low; level released, phase idle, flags cleared,
// configuration registers at their default values. No clearing pass.
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_unit
// Debounces an active-low button and classifies short, long and long-long presses.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier_unit import kdpc_pkg::*; #(
  parameter int unsigned TimeWidth = TimeWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [CfgWidth-1:0]    cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   pin_level_i,
  input  wire logic [31:0]            now_time_i,
  input  wire logic                   inhibit_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        debounced_level_o,
  output logic [1:0]                  press_event_o,
  output logic                        press_began_o,
  output logic                        long_reached_o,
  output logic                        long_long_reached_o
);

  kdpc_cfg_t    cfg_q;
  logic         in_vld_q, in_vld_d;
  kdpc_item_t   item_q;
  logic         out_vld_q, out_vld_d;
  kdpc_result_t res_q;
  kdpc_result_t res;
  logic         out_ready;
  logic         advance;
  logic         accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_limit <= DebounceLimitRst;
      cfg_q.long_time      <= LongTimeRst;
      cfg_q.long_long_time <= LongLongTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit <= cfg_data_i[7:0];
        REG_LONG_TIME:      cfg_q.long_time      <= cfg_data_i;
        REG_LONG_LONG_TIME: cfg_q.long_long_time <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.pin_level <= pin_level_i;
      item_q.now_time  <= now_time_i;
      item_q.inhibit   <= inhibit_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  kdpc_tracker #(
    .TimeWidth(TimeWidth)
  ) u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .res_o  (res)
  );

  assign out_valid_o         = out_vld_q;
  assign debounced_level_o   = res_q.debounced_level;
  assign press_event_o       = res_q.press_event;
  assign press_began_o       = res_q.press_began;
  assign long_reached_o      = res_q.long_reached;
  assign long_long_reached_o = res_q.long_long_reached;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Key debounce and press classifier testbench
// Drives sampling ticks through the valid/stall request channel, with random
// gaps on the input side and random stalls on the result side. A scoreboard
// class mirrors the debouncer and the press-phase machine, predicts each
// result and compares it field by field with what the block returns. Several
// register settings are visited, the low and high extremes among them.
// ----------------------------------------------------------------------------
module testbench import kdpc_pkg::*; ();

  class press_tracker;
    logic [7:0]   debounce_limit;
    logic [31:0]  long_time;
    logic [31:0]  long_long_time;
    logic         level;
    logic [7:0]   count;
    kdpc_phase_e  press_phase;
    logic [31:0]  start_time;
    logic         long_flag;
    logic         long_long_flag;
    kdpc_result_t expected_results[$];
    int           failures;

    function new();
      debounce_limit = DebounceLimitRst;
      long_time      = LongTimeRst;
      long_long_time = LongLongTimeRst;
      level          = 1'b1;
      count          = '0;
      press_phase    = PH_IDLE;
      start_time     = '0;
      long_flag      = 1'b0;
      long_long_flag = 1'b0;
      failures       = 0;
    endfunction

    function void set_config(logic [7:0] lim, logic [31:0] lt, logic [31:0] llt);
      debounce_limit = lim;
      long_time      = lt;
      long_long_time = llt;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_tick(kdpc_item_t tick);
      kdpc_result_t r;
      logic [31:0]  elapsed;
      r.press_event = EV_NONE;
      r.press_began = 1'b0;
      if (!tick.inhibit) begin
        if (tick.pin_level == level) begin
          count = '0;
        end else begin
          if (count != CountMax) count++;
          if (count > debounce_limit) begin
            level = tick.pin_level;
            count = '0;
          end
        end
        case (press_phase)
          PH_HELD: begin
            if (level == 1'b0) begin
              elapsed = tick.now_time - start_time;
              if (elapsed > long_time) long_flag = 1'b1;
              if (elapsed > long_long_time) long_long_flag = 1'b1;
            end else begin
              press_phase = PH_REPORT;
            end
          end
          PH_REPORT: begin
            if (long_long_flag) begin
              long_flag = 1'b0;
              r.press_event = EV_LONG_LONG;
            end else if (long_flag) begin
              r.press_event = EV_LONG;
            end else begin
              r.press_event = EV_SHORT;
            end
            press_phase = PH_IDLE;
          end
          default: begin
            press_phase = PH_IDLE;
            if (level == 1'b0) begin
              start_time     = tick.now_time;
              press_phase    = PH_HELD;
              long_flag      = 1'b0;
              long_long_flag = 1'b0;
              r.press_began  = 1'b1;
            end
          end
        endcase
      end
      r.debounced_level   = level;
      r.long_reached      = long_flag;
      r.long_long_reached = long_long_flag;
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(kdpc_result_t got);
      kdpc_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, got);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      check_field("debounced_level", want.debounced_level, got.debounced_level);
      check_field("press_event", want.press_event, got.press_event);
      check_field("press_began", want.press_began, got.press_began);
      check_field("long_reached", want.long_reached, got.long_reached);
      check_field("long_long_reached", want.long_long_reached, got.long_long_reached);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]    cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall_o;
  logic                   pin_level = 1'b1;
  logic [31:0]            now_time = '0;
  logic                   inhibit = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall = 1'b0;
  logic                   debounced_level_o;
  logic [1:0]             press_event_o;
  logic                   press_began_o;
  logic                   long_reached_o;
  logic                   long_long_reached_o;

  press_tracker tracker = new();
  logic [31:0]  sys_time = '0;
  bit           gaps_on = 1'b1;
  int           ticks_sent = 0;

  key_debounce_press_classifier_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .pin_level_i         (pin_level),
    .now_time_i          (now_time),
    .inhibit_i           (inhibit),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .debounced_level_o   (debounced_level_o),
    .press_event_o       (press_event_o),
    .press_began_o       (press_began_o),
    .long_reached_o      (long_reached_o),
    .long_long_reached_o (long_long_reached_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // accepted requests and results, sampled at the edge
  always @(posedge clk_i) begin
    kdpc_item_t   tick;
    kdpc_result_t seen;
    if (in_valid && !in_stall_o) begin
      tick.pin_level = pin_level;
      tick.now_time  = now_time;
      tick.inhibit   = inhibit;
      tracker.note_tick(tick);
    end
    if (out_valid_o && !out_stall) begin
      seen.debounced_level   = debounced_level_o;
      seen.press_event       = kdpc_event_e'(press_event_o);
      seen.press_began       = press_began_o;
      seen.long_reached      = long_reached_o;
      seen.long_long_reached = long_long_reached_o;
      tracker.check_result(seen);
    end
  end

  // result-side stall: runs of free flow, short stalls and the odd long one
  initial begin
    int hold;
    int pick;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall <= 1'b0;
          hold = $urandom_range(0, 20);
        end else if (pick < 90) begin
          out_stall <= 1'b1;
          hold = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic drive_tick(logic pin, logic [31:0] now, logic inh);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    pin_level <= pin;
    now_time  <= now;
    inhibit   <= inh;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
  endtask

  task automatic emit(logic pin);
    if ($urandom_range(0, 99) < 3) sys_time = $urandom;
    else sys_time += $urandom_range(0, 8);
    drive_tick(pin, sys_time, $urandom_range(0, 99) < 6);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(kdpc_reg_e idx, logic [CfgWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [7:0] lim, logic [31:0] lt, logic [31:0] llt);
    wait_drained();
    write_reg(REG_DEBOUNCE_LIMIT, {24'd0, lim});
    write_reg(REG_LONG_TIME, lt);
    write_reg(REG_LONG_LONG_TIME, llt);
    cfg_we <= 1'b0;
    tracker.set_config(lim, lt, llt);
  endtask

  // idle with bounce, held press with glitches, clean release; some pure noise
  task automatic press_sequence(int lim);
    gaps_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(4, 20)) emit($urandom_range(0, 1));
    end else begin
      repeat ($urandom_range(0, lim + 3)) emit($urandom_range(0, 99) >= 20);
      repeat ($urandom_range(lim + 1, lim + 40)) emit($urandom_range(0, 99) < 8);
      repeat ($urandom_range(lim + 1, lim + 6)) emit(1'b1);
    end
    if ($urandom_range(0, 19) == 0) wait_drained();
  endtask

  task automatic run_phase(int lim, logic [31:0] lt, logic [31:0] llt, int n);
    int first;
    apply_settings(lim[7:0], lt, llt);
    first = ticks_sent;
    while (ticks_sent - first < n) press_sequence(lim);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: bounce, wrap of the time, thresholds at and past the edge
    drive_tick(1'b1, 32'h0000_0000, 1'b0);
    drive_tick(1'b0, 32'hFFFF_FFFF, 1'b1);
    drive_tick(1'b0, 32'd10, 1'b0);
    drive_tick(1'b0, 32'd20, 1'b0);
    drive_tick(1'b1, 32'd30, 1'b0);
    for (int k = 0; k < 6; k++) drive_tick(1'b0, 32'hFFFF_0000 + k, 1'b0);
    drive_tick(1'b0, 32'hFFFF_0005 + 32'd30000, 1'b0);
    drive_tick(1'b0, 32'hFFFF_0005 + 32'd30001, 1'b0);
    drive_tick(1'b0, 32'hFFFF_0005 + 32'd50000, 1'b0);
    drive_tick(1'b0, 32'hFFFF_0005 + 32'd50001, 1'b0);
    drive_tick(1'b0, 32'h0000_0100, 1'b0);
    drive_tick(1'b1, 32'h0000_0200, 1'b1);
    for (int k = 0; k < 6; k++) drive_tick(1'b1, 32'h0000_0300 + k, 1'b0);
    drive_tick(1'b1, 32'h0000_0400, 1'b0);

    sys_time = $urandom;
    run_phase(0, 32'd0, 32'd0, 30);
    run_phase(2, 32'd40, 32'd100, 30);
    run_phase(1, 32'hFFFF_FFFF, 32'd60, 25);
    run_phase(4, 32'd25, 32'hFFFF_FFFF, 25);

    // limit 255: count saturates, level must never flip
    apply_settings(8'd255, 32'd30, 32'd50);
    gaps_on = 1'b1;
    repeat (265) emit(1'b0);

    repeat (2) run_phase($urandom_range(0, 6), $urandom_range(0, 80),
                         $urandom_range(0, 160), 25);
    run_phase(DebounceLimitRst, LongTimeRst, LongLongTimeRst, 20);

    wait_drained();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
